>>> design/lagrangian_bound_evaluator_unit_macros.svh
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator: assertion macros
// Shared concurrent-assertion wrappers for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef LAGRANGIAN_BOUND_EVALUATOR_UNIT_MACROS_SVH
`define LAGRANGIAN_BOUND_EVALUATOR_UNIT_MACROS_SVH

// Checked on every edge outside reset.
`define LBE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define LBE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/lbe_pkg.sv
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator package
// Sizes, register codes and the records passed between the block's parts.
// ----------------------------------------------------------------------------
package lbe_pkg;

   // Build-time sizing
   localparam int NUM_RES        = 4;    // resources in use, 1..4
   localparam int MAX_ITEMS      = 64;   // scored items per class, 2..64
   localparam int NUM_COST_PORTS = 4;

   // Field widths
   localparam int PROFIT_W = 16;
   localparam int COST_W   = 16;
   localparam int MULT_W   = 24;
   localparam int CAP_W    = 32;
   localparam int SCORE_W  = 32;
   localparam int OUT_IDX_W = 6;
   localparam int BOUND_W  = 59;
   localparam int FRAC_W   = 16;

   // Derived widths
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W      = $clog2(MAX_ITEMS);
   localparam int PROD_W     = MULT_W + COST_W;
   localparam int PSUM_W     = PROD_W + $clog2(NUM_RES);
   localparam int RAW_W      = PSUM_W + 2;
   localparam int CPROD_W    = MULT_W + CAP_W;
   localparam int CAP_TERM_W = CPROD_W + $clog2(NUM_RES);
   localparam int BSUM_W     = BOUND_W + 2;

   localparam logic [BOUND_W-1:0] BOUND_MAX = '1;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_BASE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_BASE  = 4'd4;

   // Front-to-back queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Result buffer
   localparam int R_DEPTH = 2;
   localparam int R_PTR_W = $clog2(R_DEPTH);
   localparam int R_CNT_W = $clog2(R_DEPTH + 1);

   typedef struct packed {
      logic [SCORE_W-1:0] score;      // clamped score, 0 when not positive
      logic               class_end;
      logic               set_end;
   } lbe_entry_type;

   typedef struct packed {
      logic               empty;
      logic [Q_CNT_W-1:0] count;
   } lbe_qstat_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] chosen_index;
      logic [SCORE_W-1:0]   class_value;
      logic [BOUND_W-1:0]   bound_value;
      logic                 is_final;
   } lbe_result_type;

endpackage

>>> design/lagrangian_bound_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator
// Scores multiple-choice knapsack items, picks each class's best item and
// accumulates the Lagrangian bound.
// ----------------------------------------------------------------------------
// One item beat is taken every clock cycle while req_full is low. A class's
// result reaches the rsp_ ports via the front-end registers, the queue and
// the result buffer. The back end retires one item per cycle while the
// result buffer has room; the front end's multipliers are pipelined. Each
// score is profit * 2^16 minus the sum of mult_k * cost_k; only a strictly
// greater positive score replaces the class best, so a class without a
// positive score reports index 0 and value 0. Items past MAX_ITEMS in one
// class are not scored. end_of_set also closes the class; its result
// carries the bound with the capacity term added, is_final set, and all
// running state is then cleared. The bound saturates at 2^59 - 1. csr_ready
// is always high; register writes are expected while the block is idle,
// and a write reaches the capacity term via the product registers. Writes
// to indexes past cap_3 are dropped. No initialization pass after reset.
// ----------------------------------------------------------------------------
module lagrangian_bound_evaluator_unit (
   input  logic                               clock,
   input  logic                               reset,
   // item channel
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [lbe_pkg::PROFIT_W-1:0]       req_profit,
   input  logic [lbe_pkg::COST_W-1:0]         req_cost_0,
   input  logic [lbe_pkg::COST_W-1:0]         req_cost_1,
   input  logic [lbe_pkg::COST_W-1:0]         req_cost_2,
   input  logic [lbe_pkg::COST_W-1:0]         req_cost_3,
   input  logic                               req_end_of_class,
   input  logic                               req_end_of_set,
   // result channel
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [lbe_pkg::OUT_IDX_W-1:0]      rsp_chosen_index,
   output logic [lbe_pkg::SCORE_W-1:0]        rsp_class_value,
   output logic [lbe_pkg::BOUND_W-1:0]        rsp_bound_value,
   output logic                               rsp_is_final,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lbe_pkg::*;

   logic [MULT_W-1:0]     mult [NUM_RES];
   logic [CAP_TERM_W-1:0] cap_term;
   logic [COST_W-1:0]     req_cost [NUM_COST_PORTS];

   logic                  accept;
   logic                  f_valid;
   lbe_entry_type         f_entry;
   lbe_entry_type         q_data;
   lbe_qstat_type         q_status;
   logic                  q_pop;
   lbe_result_type        res_data;
   logic [Q_CNT_W:0]      credit_used;

   assign csr_ready = 1'b1;

   assign req_cost[0] = req_cost_0;
   assign req_cost[1] = req_cost_1;
   assign req_cost[2] = req_cost_2;
   assign req_cost[3] = req_cost_3;

   // Beats in the front pipeline already own a queue slot, so the front
   // never stalls and full follows from registered state only.
   assign credit_used = (Q_CNT_W + 1)'(q_status.count) + (Q_CNT_W + 1)'(f_valid);
   assign req_full    = (credit_used >= (Q_CNT_W + 1)'(Q_DEPTH));
   assign accept      = req_push && !req_full;

   lbe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .mult     (mult),
      .cap_term (cap_term)
   );

   lbe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_profit    (req_profit),
      .in_cost      (req_cost),
      .in_class_end (req_end_of_class),
      .in_set_end   (req_end_of_set),
      .mult         (mult),
      .out_valid    (f_valid),
      .out_entry    (f_entry)
   );

   lbe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (f_valid),
      .wr_data (f_entry),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .status  (q_status)
   );

   lbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .cap_term  (cap_term),
      .res_empty (rsp_empty),
      .res_pop   (rsp_pop),
      .res_data  (res_data)
   );

   assign rsp_chosen_index = res_data.chosen_index;
   assign rsp_class_value  = res_data.class_value;
   assign rsp_bound_value  = res_data.bound_value;
   assign rsp_is_final     = res_data.is_final;

endmodule

>>> design/lbe_csr.sv
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator: register file
// Multiplier and capacity registers, plus the registered capacity term.
// ----------------------------------------------------------------------------
module lbe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [lbe_pkg::CSR_IDX_W-1:0]      wr_index,
   input  logic [lbe_pkg::CSR_DATA_W-1:0]     wr_data,
   output logic [lbe_pkg::MULT_W-1:0]         mult [lbe_pkg::NUM_RES],
   output logic [lbe_pkg::CAP_TERM_W-1:0]     cap_term
);
   import lbe_pkg::*;

   logic [MULT_W-1:0]     mult_ff  [NUM_RES];
   logic [MULT_W-1:0]     mult_in  [NUM_RES];
   logic [CAP_W-1:0]      cap_ff   [NUM_RES];
   logic [CAP_W-1:0]      cap_in   [NUM_RES];
   logic [CPROD_W-1:0]    cprod_ff [NUM_RES];
   logic [CPROD_W-1:0]    cprod_in [NUM_RES];
   logic [CAP_TERM_W-1:0] cap_term_ff;
   logic [CAP_TERM_W-1:0] cap_term_in;

   always_comb begin
      cap_term_in = '0;
      for (int k = 0; k < NUM_RES; k++) begin
         mult_in[k] = mult_ff[k];
         cap_in[k]  = cap_ff[k];
         if (wr_en && wr_index == CSR_MULT_BASE + CSR_IDX_W'(k)) begin
            mult_in[k] = wr_data[MULT_W-1:0];
         end
         if (wr_en && wr_index == CSR_CAP_BASE + CSR_IDX_W'(k)) begin
            cap_in[k] = wr_data[CAP_W-1:0];
         end
         cprod_in[k] = CPROD_W'(mult_ff[k]) * CPROD_W'(cap_ff[k]);
         cap_term_in = cap_term_in + CAP_TERM_W'(cprod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_RES; k++) begin
            mult_ff[k]  <= '0;
            cap_ff[k]   <= '0;
            cprod_ff[k] <= '0;
         end
         cap_term_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_RES; k++) begin
            mult_ff[k]  <= mult_in[k];
            cap_ff[k]   <= cap_in[k];
            cprod_ff[k] <= cprod_in[k];
         end
         cap_term_ff <= cap_term_in;
      end
   end

   assign mult     = mult_ff;
   assign cap_term = cap_term_ff;

endmodule

>>> design/lbe_front.sv
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator: front end
// Registers the cost products of each beat, then forms and clamps the score.
// ----------------------------------------------------------------------------
module lbe_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [lbe_pkg::PROFIT_W-1:0]      in_profit,
   input  logic [lbe_pkg::COST_W-1:0]        in_cost [lbe_pkg::NUM_COST_PORTS],
   input  logic                              in_class_end,
   input  logic                              in_set_end,
   input  logic [lbe_pkg::MULT_W-1:0]        mult [lbe_pkg::NUM_RES],
   output logic                              out_valid,
   output lbe_pkg::lbe_entry_type            out_entry
);
   import lbe_pkg::*;

   logic                 valid_ff,     valid_in;
   logic [PROFIT_W-1:0]  profit_ff,    profit_in;
   logic                 class_end_ff, class_end_in;
   logic                 set_end_ff,   set_end_in;
   logic [PROD_W-1:0]    prod_ff [NUM_RES];
   logic [PROD_W-1:0]    prod_in [NUM_RES];

   logic [PSUM_W-1:0]        psum;
   logic signed [RAW_W-1:0]  raw_score;

   // stage 1: one multiplier per resource
   always_comb begin
      valid_in     = in_valid;
      profit_in    = in_profit;
      class_end_in = in_class_end | in_set_end;   // end of set closes the class
      set_end_in   = in_set_end;
      for (int k = 0; k < NUM_RES; k++) begin
         prod_in[k] = PROD_W'(mult[k]) * PROD_W'(in_cost[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      profit_ff    <= profit_in;
      class_end_ff <= class_end_in;
      set_end_ff   <= set_end_in;
      for (int k = 0; k < NUM_RES; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   // stage 2: profit in Q.16 less the cost sum; only positive scores matter
   always_comb begin
      psum = '0;
      for (int k = 0; k < NUM_RES; k++) begin
         psum = psum + PSUM_W'(prod_ff[k]);
      end
      raw_score = $signed(RAW_W'({profit_ff, {FRAC_W{1'b0}}})) - $signed(RAW_W'(psum));
      out_entry.class_end = class_end_ff;
      out_entry.set_end   = set_end_ff;
      if (raw_score > 0) begin
         out_entry.score = raw_score[SCORE_W-1:0];
      end else begin
         out_entry.score = '0;
      end
   end

   assign out_valid = valid_ff;

endmodule

>>> design/lbe_queue.sv
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator: decoupling queue
// Small register queue between the scoring front end and the back end.
// ----------------------------------------------------------------------------
module lbe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  lbe_pkg::lbe_entry_type  wr_data,
   input  logic                    rd_en,
   output lbe_pkg::lbe_entry_type  rd_data,
   output lbe_pkg::lbe_qstat_type  status
);
   import lbe_pkg::*;

   lbe_entry_type       mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

>>> design/lbe_back.sv
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator: back end
// Class maximum, running bound with saturation, and the result buffer.
// ----------------------------------------------------------------------------
module lbe_back (
   input  logic                              clock,
   input  logic                              reset,
   input  lbe_pkg::lbe_qstat_type            q_status,
   input  lbe_pkg::lbe_entry_type            q_data,
   output logic                              q_pop,
   input  logic [lbe_pkg::CAP_TERM_W-1:0]    cap_term,
   output logic                              res_empty,
   input  logic                              res_pop,
   output lbe_pkg::lbe_result_type           res_data
);
   import lbe_pkg::*;

   logic [CNT_W-1:0]    count_ff,    count_in;
   logic [SCORE_W-1:0]  best_ff,     best_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [BOUND_W-1:0]  bound_ff,    bound_in;

   lbe_result_type      rbuf_ff [R_DEPTH];
   logic [R_PTR_W-1:0]  rwr_ff, rwr_in;
   logic [R_PTR_W-1:0]  rrd_ff, rrd_in;
   logic [R_CNT_W-1:0]  rcnt_ff, rcnt_in;

   logic                      fire, scored, take, res_push, res_take;
   logic [SCORE_W-1:0]        new_best;
   logic [IDX_W-1:0]          new_idx;
   logic [IDX_W+OUT_IDX_W-1:0] idx_ext;
   logic [CAP_TERM_W-1:0]     cap_sel;
   logic [BSUM_W-1:0]         bsum;
   logic [BOUND_W-1:0]        bound_sat;
   lbe_result_type            result;

   always_comb begin
      fire     = !q_status.empty && (rcnt_ff != R_CNT_W'(R_DEPTH));
      scored   = (count_ff < CNT_W'(MAX_ITEMS));
      take     = scored && (q_data.score > best_ff);
      new_best = take ? q_data.score : best_ff;
      new_idx  = take ? count_ff[IDX_W-1:0] : best_idx_ff;
      idx_ext  = {{OUT_IDX_W{1'b0}}, new_idx};
      cap_sel  = q_data.set_end ? cap_term : '0;
      // saturation is monotone, so one clamp covers the chain of adds
      bsum      = BSUM_W'(bound_ff) + BSUM_W'(new_best) + BSUM_W'(cap_sel);
      bound_sat = (bsum > BSUM_W'(BOUND_MAX)) ? BOUND_MAX : bsum[BOUND_W-1:0];

      result.chosen_index = idx_ext[OUT_IDX_W-1:0];
      result.class_value  = new_best;
      result.bound_value  = bound_sat;
      result.is_final     = q_data.set_end;

      count_in    = count_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      bound_in    = bound_ff;
      if (fire) begin
         if (q_data.class_end) begin
            count_in    = '0;
            best_in     = '0;
            best_idx_in = '0;
            bound_in    = q_data.set_end ? '0 : bound_sat;
         end else begin
            count_in    = scored ? count_ff + 1'b1 : count_ff;
            best_in     = new_best;
            best_idx_in = new_idx;
         end
      end

      res_push = fire && q_data.class_end;
      res_take = res_pop && (rcnt_ff != '0);
      rwr_in   = rwr_ff;
      rrd_in   = rrd_ff;
      rcnt_in  = rcnt_ff;
      if (res_push) begin
         rwr_in = (rwr_ff == R_PTR_W'(R_DEPTH - 1)) ? '0 : rwr_ff + 1'b1;
      end
      if (res_take) begin
         rrd_in = (rrd_ff == R_PTR_W'(R_DEPTH - 1)) ? '0 : rrd_ff + 1'b1;
      end
      if (res_push && !res_take) begin
         rcnt_in = rcnt_ff + 1'b1;
      end else if (res_take && !res_push) begin
         rcnt_in = rcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         best_ff     <= '0;
         best_idx_ff <= '0;
         bound_ff    <= '0;
         rwr_ff      <= '0;
         rrd_ff      <= '0;
         rcnt_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
         bound_ff    <= bound_in;
         rwr_ff      <= rwr_in;
         rrd_ff      <= rrd_in;
         rcnt_ff     <= rcnt_in;
      end
      if (res_push) begin
         rbuf_ff[rwr_ff] <= result;
      end
   end

   assign q_pop     = fire;
   assign res_empty = (rcnt_ff == '0);
   assign res_data  = rbuf_ff[rrd_ff];

endmodule

>>> design/lbe_checker.sv
// ----------------------------------------------------------------------------
// Lagrangian bound evaluator: port checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "lagrangian_bound_evaluator_unit_macros.svh"

module lbe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic [lbe_pkg::OUT_IDX_W-1:0]      rsp_chosen_index,
   input logic [lbe_pkg::SCORE_W-1:0]        rsp_class_value,
   input logic [lbe_pkg::BOUND_W-1:0]        rsp_bound_value,
   input logic                               rsp_is_final
);
   import lbe_pkg::*;

   // nothing is pending right after reset
   `LBE_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> (rsp_empty && !req_full), "block not idle after reset")

   // a waiting result holds until popped
   `LBE_ASSERT(a_result_holds, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_chosen_index) && $stable(rsp_class_value) && $stable(rsp_bound_value) && $stable(rsp_is_final)), "waiting result changed")

   // the running bound already contains the class value
   `LBE_ASSERT(a_bound_covers_class, clock, reset, !rsp_empty |-> (rsp_bound_value >= BOUND_W'(rsp_class_value)), "bound below class value")

   // a class without a positive score keeps index 0
   `LBE_ASSERT(a_zero_class_index, clock, reset, (!rsp_empty && rsp_class_value == '0) |-> (rsp_chosen_index == '0), "nonzero index for zero class value")

endmodule

bind lagrangian_bound_evaluator_unit lbe_checker u_lbe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_chosen_index (rsp_chosen_index),
   .rsp_class_value  (rsp_class_value),
   .rsp_bound_value  (rsp_bound_value),
   .rsp_is_final     (rsp_is_final)
);
